// ===== sv/lru8_rank_state_update_macros.svh =====
// Assertion macros for the 8-way LRU rank update block.
// Pulled in by the RTL files that carry checks; no other dependencies.
`ifndef LRU8_RANK_STATE_UPDATE_MACROS_SVH
`define LRU8_RANK_STATE_UPDATE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define LRU8_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lru8 check failed");
// Next-cycle implication, disabled while reset is asserted
`define LRU8_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru8 check failed");
`else
`define LRU8_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define LRU8_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/lru8_pkg.sv =====
// Shared types and constant tables for the 8-way LRU rank update block.
// No dependencies; used by lru8_rank_cell and lru8_rank_state_update.
package lru8_pkg;

    localparam int WAYS = 8;
    localparam logic [15:0] RANK_MAX = 16'd40319;

    // Lehmer digit weights, indexed by position in the decoded order
    localparam logic [7:0][15:0] WEIGHT = {
        16'd1, 16'd1, 16'd2, 16'd6, 16'd24, 16'd120, 16'd720, 16'd5040
    };

    // Weights used when re-encoding; the last position carries no weight
    localparam logic [7:0][15:0] NXT_WEIGHT = {
        16'd0, 16'd1, 16'd2, 16'd6, 16'd24, 16'd120, 16'd720, 16'd5040
    };

    typedef logic [7:0][7:0][15:0] t_step_tab;

    // Multiples k * WEIGHT[p] for k = 0..7, used as digit thresholds
    function automatic t_step_tab build_steps();
        t_step_tab tab;
        for (int p = 0; p < WAYS; p++) begin
            for (int k = 0; k < WAYS; k++) begin
                tab[p][k] = 16'(k * WEIGHT[p]);
            end
        end
        return tab;
    endfunction

    localparam t_step_tab STEP = build_steps();

    typedef struct packed {
        logic [15:0] order_rank;
        logic [2:0]  touched_way;
    } t_in;

    typedef struct packed {
        logic [15:0] next_rank;
        logic [2:0]  victim_way;
    } t_out;

    // Word handed from one cell to the next
    typedef struct packed {
        logic        valid;
        logic [15:0] rem;      // remainder of the incoming rank still to decode
        logic [7:0]  avail;    // ways not yet placed in the order
        logic [2:0]  touched;  // accessed way
        logic        seen;     // accessed way already met in the order
        logic [15:0] acc;      // partial rank of the updated order
        logic [2:0]  way;      // way placed by this cell
    } t_link;

endpackage

// ===== sv/lru8_rank_cell.sv =====
// One cell of the rank chain: decodes one Lehmer digit, places one way and
// adds its share to the new rank. Depends on lru8_pkg and the macros header.
`include "lru8_rank_state_update_macros.svh"

module lru8_rank_cell
    import lru8_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [2:0]  i_pos,
    input  t_link       i_link,
    output logic        o_ready,
    output t_link       o_link,
    input  logic        i_ready
);

    t_link       r_link;
    t_link       n_link;
    logic [2:0]  digit;
    logic [2:0]  way;
    logic [3:0]  cnt;
    logic        found;
    logic [2:0]  adj;
    logic [2:0]  npos;
    logic [18:0] prod;
    logic        take;

    // Advance when the stage is empty or its word moves on
    assign o_ready = !r_link.valid || i_ready;
    assign take    = i_link.valid && o_ready;

    // Extract the digit by comparing against constant multiples of the weight
    always_comb begin
        digit = 3'd0;
        for (int k = 1; k < WAYS; k++) begin
            if (i_link.rem >= STEP[i_pos][k]) begin
                digit = 3'(k);
            end
        end
    end

    // Pick the digit-th free way in ascending order
    always_comb begin
        cnt   = 4'd0;
        way   = 3'd0;
        found = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            if (i_link.avail[w]) begin
                if (!found && cnt == {1'b0, digit}) begin
                    way   = 3'(w);
                    found = 1'b1;
                end
                cnt = cnt + 4'd1;
            end
        end
    end

    // Digit of this way in the updated order, and the position it lands on
    always_comb begin
        if (i_link.seen) begin
            adj  = digit;
            npos = i_pos;
        end else begin
            adj  = digit - {2'd0, (i_link.touched < way)};
            npos = i_pos + 3'd1;
        end
        prod = adj * NXT_WEIGHT[npos];
    end

    // Build the word for the next cell
    always_comb begin
        n_link         = i_link;
        n_link.rem     = i_link.rem - STEP[i_pos][digit];
        n_link.avail   = i_link.avail & ~(8'd1 << way);
        n_link.seen    = i_link.seen || (way == i_link.touched);
        n_link.way     = way;
        if (way != i_link.touched) begin
            n_link.acc = i_link.acc + prod[15:0];
        end
    end

    // Hold the stage register; only the valid bit is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.valid <= 1'b0;
        end else if (o_ready) begin
            r_link.valid <= i_link.valid;
        end
        if (take) begin
            r_link.rem     <= n_link.rem;
            r_link.avail   <= n_link.avail;
            r_link.touched <= n_link.touched;
            r_link.seen    <= n_link.seen;
            r_link.acc     <= n_link.acc;
            r_link.way     <= n_link.way;
        end
    end

    assign o_link = r_link;

    `LRU8_ASSERT_IMPL(a_free_count, i_clk, i_rst_n, r_link.valid, $countones(r_link.avail) == (4'd7 - {1'b0, i_pos}))
    `LRU8_ASSERT_IMPL(a_way_taken, i_clk, i_rst_n, r_link.valid, !r_link.avail[r_link.way])
    `LRU8_ASSERT_IMPL(a_rem_bound, i_clk, i_rst_n, r_link.valid, r_link.rem < WEIGHT[i_pos])
    `LRU8_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_link.valid && !i_ready, r_link.valid)

endmodule

// ===== sv/lru8_rank_state_update.sv =====
// 8-way true-LRU rank update: an accepted input word passes the stage register
// of each cell to o_valid; one word accepted per cycle when the output drains.
// The rate is set by the chain of eight rank cells, one digit per cell, each
// with its own stage register; a stall holds the chain, collapsing bubbles.
// Reset (synchronous, active low) empties every stage; no other state exists.
module lru8_rank_state_update
    import lru8_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_link       w_link [0:WAYS];
    logic        w_rdy  [0:WAYS];
    logic [15:0] rank_sat;
    logic [18:0] front;

    // Clamp out-of-range ranks, seed the new rank with the accessed way
    assign rank_sat = (i_data.order_rank > RANK_MAX) ? RANK_MAX : i_data.order_rank;
    assign front    = i_data.touched_way * WEIGHT[0];

    always_comb begin
        w_link[0].valid   = i_valid;
        w_link[0].rem     = rank_sat;
        w_link[0].avail   = 8'hFF;
        w_link[0].touched = i_data.touched_way;
        w_link[0].seen    = 1'b0;
        w_link[0].acc     = front[15:0];
        w_link[0].way     = 3'd0;
    end

    // Chain of cells, one per order position
    for (genvar g = 0; g < WAYS; g++) begin : g_cell
        lru8_rank_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pos   (3'(g)),
            .i_link  (w_link[g]),
            .o_ready (w_rdy[g]),
            .o_link  (w_link[g+1]),
            .i_ready (w_rdy[g+1])
        );
    end

    assign w_rdy[WAYS] = i_ready;
    assign o_ready     = w_rdy[0];

    // Last stage is the output register; its way is the old LRU way
    assign o_valid           = w_link[WAYS].valid;
    assign o_data.next_rank  = w_link[WAYS].acc;
    assign o_data.victim_way = w_link[WAYS].way;

endmodule
